// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue core
// Sizes, action and status codes, cell operations and the neighbour link type.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int GRP    = 8;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_ROTATE     = 3'd5
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } cell_link_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell: one slot of the deque chain
// Holds one word and its valid bit; moves data to or from its neighbours.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::cell_op_e          op_i,
  input  logic [dq_pkg::DATA_W-1:0] value_i,
  input  logic [dq_pkg::DATA_W-1:0] head_i,
  input  dq_pkg::cell_link_t        prev_i,
  input  dq_pkg::cell_link_t        next_i,
  output dq_pkg::cell_link_t        link_o,
  output logic                      last_o
);

  logic                      valid_q, valid_d;
  logic [dq_pkg::DATA_W-1:0] data_q, data_d;

  assign last_o = valid_q & ~next_i.valid;
  assign link_o = '{valid: valid_q, data: data_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (op_i)
      dq_pkg::OP_PUSH_FRONT: begin
        valid_d = prev_i.valid;
        data_d  = prev_i.data;
      end
      dq_pkg::OP_PUSH_BACK: begin
        // first free slot takes the new word
        if (!valid_q && prev_i.valid) begin
          valid_d = 1'b1;
          data_d  = value_i;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        valid_d = next_i.valid;
        data_d  = next_i.data;
      end
      dq_pkg::OP_POP_BACK: begin
        if (last_o) begin
          valid_d = 1'b0;
        end
      end
      dq_pkg::OP_ROTATE: begin
        // front word wraps round to the back slot
        if (last_o) begin
          data_d = head_i;
        end else if (valid_q) begin
          data_d = next_i.data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== rtl/core/dq_pick.sv =====
// ----------------------------------------------------------------------------
// dq_pick: registered selection of the back word
// Gathers the word of the marked cell in groups, registers the groups and
// merges them in the following cycle.
// ----------------------------------------------------------------------------
module dq_pick (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [dq_pkg::DEPTH-1:0]  sel_i,
  input  logic [dq_pkg::DATA_W-1:0] data_i [dq_pkg::DEPTH],
  output logic [dq_pkg::DATA_W-1:0] data_o
);

  logic [dq_pkg::DATA_W-1:0] term [dq_pkg::NGRP][dq_pkg::GRP];
  logic [dq_pkg::DATA_W-1:0] grp_d [dq_pkg::NGRP];
  logic [dq_pkg::DATA_W-1:0] grp_q [dq_pkg::NGRP];

  for (genvar g = 0; g < dq_pkg::NGRP; g++) begin : g_grp
    for (genvar i = 0; i < dq_pkg::GRP; i++) begin : g_term
      if (g * dq_pkg::GRP + i < dq_pkg::DEPTH) begin : g_used
        assign term[g][i] = sel_i[g*dq_pkg::GRP+i] ? data_i[g*dq_pkg::GRP+i] : '0;
      end else begin : g_pad
        assign term[g][i] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < dq_pkg::NGRP; g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < dq_pkg::GRP; i++) begin
        grp_d[g] = grp_d[g] | term[g][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < dq_pkg::NGRP; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded deque of signed 32-bit words
// A chain of cells with the front word always in the first cell.
// ----------------------------------------------------------------------------
// Pushes, pop front and rejected or empty actions are each answered with one
// word, and so is pop back: the back word is picked out of the chain through
// a registered group stage before it reaches the output register. A list on
// a non-empty deque is taken first and then sends one stored word per cycle
// while the output is not stalled; an empty list is answered with one empty
// status word. The chain rotates by one cell for each word sent, showing every
// word at the front cell and leaving the contents as they were. The output
// register lets the next action be taken in the cycle its predecessor's last
// word is taken. Unused action codes are taken and dropped without any answer.
module double_ended_queue_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       action_i,
  input  logic signed [dq_pkg::DATA_W-1:0] item_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dq_pkg::DATA_W-1:0] element_o,
  output logic [1:0]                       status_o,
  output logic                             last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BACK = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [dq_pkg::CNT_W-1:0]   count_q, count_d;
  logic [dq_pkg::CNT_W-1:0]   list_cnt_q, list_cnt_d;

  logic                       out_valid_q;
  logic [dq_pkg::DATA_W-1:0]  element_q, element_d;
  dq_pkg::status_e            status_q, status_d;
  logic                       last_q, last_d;
  logic                       out_load;

  logic                       out_free, in_accept, empty, full, pick_load;
  dq_pkg::cell_op_e           cell_op;
  logic [dq_pkg::DATA_W-1:0]  value_w;
  logic [dq_pkg::DATA_W-1:0]  pick_data;
  dq_pkg::cell_link_t         link [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0]  cell_data [dq_pkg::DEPTH];
  logic [dq_pkg::DEPTH-1:0]   cell_last;

  assign value_w   = item_value_i;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~((state_q == S_IDLE) & out_free);
  assign in_accept = in_valid_i & ~in_stall_o;
  assign empty     = (count_q == '0);
  assign full      = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));

  // cell chain: cell 0 is the front
  for (genvar k = 0; k < dq_pkg::DEPTH; k++) begin : g_cell
    dq_pkg::cell_link_t prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = '{valid: 1'b1, data: value_w};
    end else begin : g_mid
      assign prev_w = link[k-1];
    end
    if (k == dq_pkg::DEPTH - 1) begin : g_end
      assign next_w = '{valid: 1'b0, data: '0};
    end else begin : g_inner
      assign next_w = link[k+1];
    end
    assign cell_data[k] = link[k].data;

    dq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .value_i (value_w),
      .head_i  (link[0].data),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .link_o  (link[k]),
      .last_o  (cell_last[k])
    );
  end

  dq_pick u_pick (
    .clk_i  (clk_i),
    .load_i (pick_load),
    .sel_i  (cell_last),
    .data_i (cell_data),
    .data_o (pick_data)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    list_cnt_d = list_cnt_q;
    cell_op    = dq_pkg::OP_HOLD;
    pick_load  = 1'b0;
    out_load   = 1'b0;
    element_d  = '0;
    status_d   = dq_pkg::ST_OK;
    last_d     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (dq_pkg::action_e'(action_i))
            dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                status_d = dq_pkg::ST_FULL;
              end else begin
                cell_op = (action_i == dq_pkg::ACT_PUSH_FRONT) ? dq_pkg::OP_PUSH_FRONT
                                                                : dq_pkg::OP_PUSH_BACK;
                count_d = count_q + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::ACT_POP_FRONT: begin
              out_load = 1'b1;
              if (empty) begin
                status_d = dq_pkg::ST_EMPTY;
              end else begin
                element_d = link[0].data;
                cell_op   = dq_pkg::OP_POP_FRONT;
                count_d   = count_q - dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                out_load = 1'b1;
                status_d = dq_pkg::ST_EMPTY;
              end else begin
                // capture the back word while its cell is dropped
                pick_load = 1'b1;
                cell_op   = dq_pkg::OP_POP_BACK;
                count_d   = count_q - dq_pkg::CNT_W'(1);
                state_d   = S_BACK;
              end
            end
            dq_pkg::ACT_LIST: begin
              if (empty) begin
                out_load = 1'b1;
                status_d = dq_pkg::ST_EMPTY;
              end else begin
                list_cnt_d = count_q;
                state_d    = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_BACK: begin
        out_load  = 1'b1;
        element_d = pick_data;
        state_d   = S_IDLE;
      end
      S_LIST: begin
        if (out_free) begin
          out_load   = 1'b1;
          element_d  = link[0].data;
          last_d     = (list_cnt_q == dq_pkg::CNT_W'(1));
          cell_op    = dq_pkg::OP_ROTATE;
          list_cnt_d = list_cnt_q - dq_pkg::CNT_W'(1);
          if (last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      list_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_cnt_q  <= list_cnt_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      element_q <= element_d;
      status_q  <= status_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_front_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[0].valid == (count_q != '0))
    else $error("front cell valid disagrees with entry count");

  a_full_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[dq_pkg::DEPTH-1].valid == (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH)))
    else $error("back cell valid disagrees with full count");

  a_one_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_last))
    else $error("more than one cell marked as back");

  a_list_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (list_cnt_q != '0) && (list_cnt_q <= count_q))
    else $error("list counter out of range");

  a_back_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BACK) |=> out_valid_q && (state_q == S_IDLE))
    else $error("pop back word not delivered");

endmodule
